/* rtl/tvi_pkg.sv */
// ----------------------------------------------------------------------------
// tvi_pkg
// shared widths, step counts and status codes of the vegetation index pipeline
// ----------------------------------------------------------------------------
package tvi_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int FRAC_BITS     = 15;
   localparam int NODATA_BITS   = 16;

   localparam int SUM_BITS      = SAMPLE_BITS + 1;
   localparam int REM_BITS      = SAMPLE_BITS + 2;
   localparam int DIV_STEPS     = FRAC_BITS + 1;
   localparam int QUO_BITS      = DIV_STEPS;
   localparam int RAD_BITS      = FRAC_BITS + 1;
   localparam int ROOT_BITS     = FRAC_BITS + 1;
   localparam int SQ_STEPS      = ROOT_BITS;
   localparam int SQ_IN_BITS    = 2 * ROOT_BITS;
   localparam int SQ_REM_BITS   = ROOT_BITS + 3;

   localparam int REQ_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((ROOT_BITS + 7) / 8) * 8;

   localparam logic [QUO_BITS-1:0]  NDVI_MAX = QUO_BITS'((1 << FRAC_BITS) - 1);
   localparam logic [QUO_BITS-1:0]  NDVI_HALF = QUO_BITS'(1 << (FRAC_BITS - 1));
   localparam logic [ROOT_BITS-1:0] TVI_MAX = ROOT_BITS'(40132);

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NODATA  = 2'd1,
      ST_NEGRAD  = 2'd2,
      ST_ZEROSUM = 2'd3
   } status_type;

endpackage

/* rtl/tvi_pixel_index.sv */
// ----------------------------------------------------------------------------
// tvi_pixel_index
// per pixel ndvi by a pipelined restoring divider, then tvi by a pipelined
// digit-by-digit square root, with no-data, zero-sum and negative flags
// ----------------------------------------------------------------------------
// pipeline: one register per quotient bit and per root bit plus input and
//   radicand stages between req transfer and rsp_tvalid
// throughput: one pixel per cycle; the whole pipeline holds while rsp stalls
// reset: synchronous, clears all stage valid bits and nodata value to zero
// ----------------------------------------------------------------------------
module tvi_pixel_index (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tvi_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // nir_sample, red_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tvi_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // tvi_value
   output logic [1:0]                          rsp_tuser,   // status
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tvi_pkg::NODATA_BITS-1:0]     csr_data     // nodata_value
);

   localparam int DS = tvi_pkg::DIV_STEPS;
   localparam int SS = tvi_pkg::SQ_STEPS;

   logic                                  pipe_en;
   logic [tvi_pkg::NODATA_BITS-1:0]       nodata_ff;

   logic [tvi_pkg::SAMPLE_BITS-1:0]       nir;
   logic [tvi_pkg::SAMPLE_BITS-1:0]       red;
   logic [tvi_pkg::SUM_BITS-1:0]          sum;
   logic [tvi_pkg::SAMPLE_BITS-1:0]       diff;
   logic                                  neg;
   tvi_pkg::status_type                   in_stat;

   // divider stages
   logic                                  d_vld_ff  [0:DS];
   logic [tvi_pkg::REM_BITS-1:0]          d_rem_ff  [0:DS];
   logic [tvi_pkg::QUO_BITS-1:0]          d_quo_ff  [0:DS];
   logic [tvi_pkg::SUM_BITS-1:0]          d_sum_ff  [0:DS];
   logic                                  d_neg_ff  [0:DS];
   tvi_pkg::status_type                   d_stat_ff [0:DS];
   logic [tvi_pkg::REM_BITS-1:0]          d_rem_in  [1:DS];
   logic [tvi_pkg::QUO_BITS-1:0]          d_quo_in  [1:DS];

   // radicand stage
   logic [tvi_pkg::QUO_BITS-1:0]          mag;
   logic [tvi_pkg::QUO_BITS-1:0]          mag_sat;
   logic                                  negrad;
   logic [tvi_pkg::RAD_BITS-1:0]          rad;
   tvi_pkg::status_type                   rad_stat;

   // square root stages
   logic                                  s_vld_ff  [0:SS];
   logic [tvi_pkg::SQ_IN_BITS-1:0]        s_val_ff  [0:SS];
   logic [tvi_pkg::SQ_REM_BITS-1:0]       s_rem_ff  [0:SS];
   logic [tvi_pkg::ROOT_BITS-1:0]         s_root_ff [0:SS];
   tvi_pkg::status_type                   s_stat_ff [0:SS];
   logic [tvi_pkg::SQ_REM_BITS-1:0]       s_rem_in  [1:SS];
   logic [tvi_pkg::ROOT_BITS-1:0]         s_root_in [1:SS];

   assign pipe_en    = !s_vld_ff[SS] || rsp_tready;
   assign req_tready = pipe_en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodata_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         nodata_ff <= csr_data;
      end
   end

   // input stage: band sum, difference and early flags
   always_comb begin
      nir  = req_tdata[tvi_pkg::SAMPLE_BITS-1:0];
      red  = req_tdata[2*tvi_pkg::SAMPLE_BITS-1:tvi_pkg::SAMPLE_BITS];
      sum  = {1'b0, nir} + {1'b0, red};
      neg  = red > nir;
      diff = neg ? red - nir : nir - red;
      if (nir == nodata_ff) begin
         in_stat = tvi_pkg::ST_NODATA;
      end else if (sum == '0) begin
         in_stat = tvi_pkg::ST_ZEROSUM;
      end else begin
         in_stat = tvi_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         d_vld_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         d_rem_ff[0]  <= tvi_pkg::REM_BITS'(diff);
         d_quo_ff[0]  <= '0;
         d_sum_ff[0]  <= sum;
         d_neg_ff[0]  <= neg;
         d_stat_ff[0] <= in_stat;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < DS; k++) begin : g_div
      logic                         ge;
      logic [tvi_pkg::REM_BITS-1:0] nrem;

      assign ge          = d_rem_ff[k] >= tvi_pkg::REM_BITS'(d_sum_ff[k]);
      assign nrem        = ge ? d_rem_ff[k] - tvi_pkg::REM_BITS'(d_sum_ff[k]) : d_rem_ff[k];
      assign d_rem_in[k+1] = {nrem[tvi_pkg::REM_BITS-2:0], 1'b0};
      assign d_quo_in[k+1] = {d_quo_ff[k][tvi_pkg::QUO_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            d_vld_ff[k+1] <= 1'b0;
         end else if (pipe_en) begin
            d_vld_ff[k+1] <= d_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            d_rem_ff[k+1]  <= d_rem_in[k+1];
            d_quo_ff[k+1]  <= d_quo_in[k+1];
            d_sum_ff[k+1]  <= d_sum_ff[k];
            d_neg_ff[k+1]  <= d_neg_ff[k];
            d_stat_ff[k+1] <= d_stat_ff[k];
         end
      end
   end

   // saturation, offset by one half and negative radicand check
   always_comb begin
      mag     = d_quo_ff[DS];
      mag_sat = (mag > tvi_pkg::NDVI_MAX) ? tvi_pkg::NDVI_MAX : mag;
      negrad  = d_neg_ff[DS] && (mag > tvi_pkg::NDVI_HALF);
      if (d_neg_ff[DS]) begin
         rad = tvi_pkg::RAD_BITS'(tvi_pkg::NDVI_HALF - mag);
      end else begin
         rad = tvi_pkg::RAD_BITS'(tvi_pkg::NDVI_HALF + mag_sat);
      end
      if (d_stat_ff[DS] != tvi_pkg::ST_OK) begin
         rad_stat = d_stat_ff[DS];
      end else if (negrad) begin
         rad_stat = tvi_pkg::ST_NEGRAD;
      end else begin
         rad_stat = tvi_pkg::ST_OK;
      end
      // flagged pixels take a zero radicand so the root comes out zero
      if (rad_stat != tvi_pkg::ST_OK) begin
         rad = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         s_vld_ff[0] <= d_vld_ff[DS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s_val_ff[0]  <= tvi_pkg::SQ_IN_BITS'({rad, {tvi_pkg::FRAC_BITS{1'b0}}});
         s_rem_ff[0]  <= '0;
         s_root_ff[0] <= '0;
         s_stat_ff[0] <= rad_stat;
      end
   end

   // digit-by-digit square root, one root bit per stage
   for (genvar k = 0; k < SS; k++) begin : g_sqrt
      logic                            ge;
      logic [tvi_pkg::SQ_REM_BITS-1:0] cur;
      logic [tvi_pkg::SQ_REM_BITS-1:0] trial;

      assign cur   = {s_rem_ff[k][tvi_pkg::SQ_REM_BITS-3:0],
                      s_val_ff[k][tvi_pkg::SQ_IN_BITS-1 -: 2]};
      assign trial = tvi_pkg::SQ_REM_BITS'({s_root_ff[k], 2'b01});
      assign ge    = cur >= trial;
      assign s_rem_in[k+1]  = ge ? cur - trial : cur;
      assign s_root_in[k+1] = {s_root_ff[k][tvi_pkg::ROOT_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            s_vld_ff[k+1] <= 1'b0;
         end else if (pipe_en) begin
            s_vld_ff[k+1] <= s_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            s_val_ff[k+1]  <= {s_val_ff[k][tvi_pkg::SQ_IN_BITS-3:0], 2'b00};
            s_rem_ff[k+1]  <= s_rem_in[k+1];
            s_root_ff[k+1] <= s_root_in[k+1];
            s_stat_ff[k+1] <= s_stat_ff[k];
         end
      end
   end

   assign rsp_tvalid = s_vld_ff[SS];
   assign rsp_tdata  = tvi_pkg::RSP_DATA_BITS'(s_root_ff[SS]);
   assign rsp_tuser  = s_stat_ff[SS];

   // flagged results carry a zero index
   a_flag_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != tvi_pkg::ST_OK) |-> rsp_tdata == '0)
      else $error("flagged result with nonzero tvi");

   // root never exceeds sqrt(1.5) in the output format
   a_tvi_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= tvi_pkg::RSP_DATA_BITS'(tvi_pkg::TVI_MAX))
      else $error("tvi out of range");

   // a stalled pipeline keeps its middle stage
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !pipe_en && s_vld_ff[0] |=> s_vld_ff[0] && $stable(s_val_ff[0]))
      else $error("radicand stage lost during stall");

   // negative radicand only when red exceeds nir
   a_negrad_src : assert property (@(posedge clock) disable iff (reset)
      d_vld_ff[DS] && (rad_stat == tvi_pkg::ST_NEGRAD) |-> d_neg_ff[DS])
      else $error("negative radicand without negative difference");

endmodule

/* tb/tvi_checker.sv */
// ----------------------------------------------------------------------------
// tvi_checker
// watches the pixel, result and csr channels of the vegetation index block,
// predicts status and tvi for every pixel transfer and compares each result
// transfer in order against the oldest prediction
// ----------------------------------------------------------------------------
module tvi_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [tvi_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // nir_sample, red_sample
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [tvi_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // tvi_value
   input  logic [1:0]                          rsp_tuser,   // status
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [tvi_pkg::NODATA_BITS-1:0]     csr_data,    // nodata_value
   output int                                  fail_count,
   output int                                  pending
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [tvi_pkg::RSP_DATA_BITS-1:0] tvi;
      tvi_pkg::status_type               status;
   } pixel_result_type;

   pixel_result_type                expected_pixels[$];
   logic [tvi_pkg::NODATA_BITS-1:0] nodata_shadow = '0;
   int                              mismatches = 0;

   function automatic logic [tvi_pkg::ROOT_BITS-1:0] root_floor(longint unsigned v);
      logic [tvi_pkg::ROOT_BITS-1:0] root;
      logic [tvi_pkg::ROOT_BITS-1:0] trial;
      longint unsigned               square;
      root = '0;
      for (int b = tvi_pkg::ROOT_BITS - 1; b >= 0; b--) begin
         trial  = root | (tvi_pkg::ROOT_BITS'(1) << b);
         square = 64'(trial) * 64'(trial);
         if (square <= v)
            root = trial;
      end
      return root;
   endfunction

   function automatic pixel_result_type predict_pixel(
         logic [tvi_pkg::SAMPLE_BITS-1:0] nir,
         logic [tvi_pkg::SAMPLE_BITS-1:0] red,
         logic [tvi_pkg::NODATA_BITS-1:0] nodata);
      pixel_result_type r;
      longint unsigned  sum;
      longint unsigned  diff;
      longint unsigned  quot;
      longint unsigned  one;
      longint           ndvi;
      longint           rad;
      logic             neg;
      r.tvi    = '0;
      r.status = tvi_pkg::ST_OK;
      one      = 64'(1) << tvi_pkg::FRAC_BITS;
      sum      = 64'(nir) + 64'(red);
      if (64'(nir) == 64'(nodata)) begin
         r.status = tvi_pkg::ST_NODATA;
      end else if (sum == 0) begin
         r.status = tvi_pkg::ST_ZEROSUM;
      end else begin
         neg  = red > nir;
         diff = neg ? 64'(red) - 64'(nir) : 64'(nir) - 64'(red);
         quot = (diff << tvi_pkg::FRAC_BITS) / sum;
         // ndvi of exactly +1 saturates
         if (!neg && quot > one - 1)
            quot = one - 1;
         ndvi = neg ? -longint'(quot) : longint'(quot);
         rad  = ndvi + longint'(one >> 1);
         if (rad < 0)
            r.status = tvi_pkg::ST_NEGRAD;
         else
            r.tvi = tvi_pkg::RSP_DATA_BITS'(root_floor(longint'(rad) << tvi_pkg::FRAC_BITS));
      end
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         expected_pixels.delete();
         nodata_shadow = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result transfer: tvi %0d status %0d",
                           rsp_tdata, rsp_tuser);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want.tvi || rsp_tuser !== want.status) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("result mismatch: expected tvi %0d status %0d, %s %0d %s %0d",
                              want.tvi, want.status, "got tvi", rsp_tdata,
                              "status", rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(
               predict_pixel(req_tdata[tvi_pkg::SAMPLE_BITS-1:0],
                             req_tdata[2*tvi_pkg::SAMPLE_BITS-1:tvi_pkg::SAMPLE_BITS],
                             nodata_shadow));
         if (csr_valid && csr_ready)
            nodata_shadow = csr_data;
      end
      fail_count <= mismatches;
      pending    <= expected_pixels.size();
   end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives pixels and nodata settings into the vegetation index block with
// random gaps and a long result stall, and gives the verdict of the checker
// ----------------------------------------------------------------------------
module tb_top;

   localparam int IDLE_PCT    = 19;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 50;
   localparam int RESET_CYCLES = 12;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [tvi_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [tvi_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]                        rsp_tuser;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [tvi_pkg::NODATA_BITS-1:0]   csr_data = '0;

   int                                fail_count;
   int                                pending;
   logic                              quiet = 1'b0;
   int                                stall_asks = 0;
   logic [tvi_pkg::NODATA_BITS-1:0]   nodata_now = '0;

   tvi_pixel_index dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   tvi_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // result side: random back-pressure plus one long hold on request
   initial begin : result_sink
      int hold_left;
      int asks_seen;
      hold_left = 0;
      asks_seen = 0;
      forever begin
         @(posedge clock);
         if (stall_asks != asks_seen) begin
            asks_seen = stall_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   task automatic send_pixel(input logic [tvi_pkg::SAMPLE_BITS-1:0] nir,
                             input logic [tvi_pkg::SAMPLE_BITS-1:0] red);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tvi_pkg::REQ_DATA_BITS'({red, nir});
      do @(posedge clock); while (!req_tready);
   endtask

   // lower valid, let every expected result arrive, then let the pipe settle
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_nodata(input logic [tvi_pkg::NODATA_BITS-1:0] value);
      csr_valid  <= 1'b1;
      csr_data   <= value;
      nodata_now = value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_pixel();
      logic [tvi_pkg::SAMPLE_BITS-1:0] nir;
      logic [tvi_pkg::SAMPLE_BITS-1:0] red;
      int                              pick;
      pick = $urandom_range(0, 99);
      nir  = tvi_pkg::SAMPLE_BITS'($urandom);
      red  = tvi_pkg::SAMPLE_BITS'($urandom);
      if (pick < 40) begin
         // full range, both samples as drawn
      end else if (pick < 55) begin
         nir = nodata_now;
      end else if (pick < 70) begin
         nir = tvi_pkg::SAMPLE_BITS'($urandom_range(0, 7));
         red = tvi_pkg::SAMPLE_BITS'($urandom_range(0, 7));
      end else if (pick < 85) begin
         // around ndvi = -0.5, the edge of the negative radicand
         nir = tvi_pkg::SAMPLE_BITS'($urandom_range(1, 21844));
         red = tvi_pkg::SAMPLE_BITS'(3 * nir + $urandom_range(0, 2) - 1);
      end else begin
         case ($urandom_range(0, 3))
            0: nir = '0;
            1: nir = '1;
            2: nir = tvi_pkg::SAMPLE_BITS'(1);
            default: nir = ~tvi_pkg::SAMPLE_BITS'(1);
         endcase
         case ($urandom_range(0, 3))
            0: red = '0;
            1: red = '1;
            2: red = tvi_pkg::SAMPLE_BITS'(1);
            default: red = ~tvi_pkg::SAMPLE_BITS'(1);
         endcase
      end
      send_pixel(nir, red);
   endtask

   initial begin : stimulus
      logic [tvi_pkg::NODATA_BITS-1:0] marker;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of nodata is zero
      send_pixel(16'd0, 16'd0);
      send_pixel(16'd0, 16'hFFFF);
      send_pixel(16'd1, 16'd0);
      send_pixel(16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'd0);
      repeat (140) send_random_pixel();
      drain_pixels();

      write_nodata(16'hFFFF);
      send_pixel(16'd0, 16'd0);
      send_pixel(16'd0, 16'hFFFF);
      send_pixel(16'd0, 16'd1);
      send_pixel(16'd1, 16'd3);
      send_pixel(16'd1, 16'd4);
      send_pixel(16'd2, 16'd5);
      send_pixel(16'hFFFE, 16'd0);
      send_pixel(16'hFFFF, 16'd7);
      send_pixel(16'hFFFE, 16'hFFFE);
      send_pixel(16'h8000, 16'h7FFF);
      send_pixel(16'd1, 16'hFFFF);
      send_pixel(16'hAAAA, 16'h5555);
      send_pixel(16'h5555, 16'hAAAA);
      quiet <= 1'b1;
      repeat (120) send_random_pixel();
      quiet <= 1'b0;
      repeat (20) send_random_pixel();
      drain_pixels();

      marker = tvi_pkg::NODATA_BITS'($urandom_range(1, 65534));
      write_nodata(marker);
      send_pixel(marker, 16'd0);
      repeat (30) send_random_pixel();
      stall_asks <= stall_asks + 1;
      repeat (140) send_random_pixel();
      drain_pixels();

      write_nodata(16'd0);
      repeat (170) send_random_pixel();
      drain_pixels();

      write_nodata(tvi_pkg::NODATA_BITS'($urandom));
      repeat (170) send_random_pixel();
      drain_pixels();

      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* tvi_pixel_index.f */
rtl/tvi_pkg.sv
rtl/tvi_pixel_index.sv
tb/tvi_checker.sv
tb/tb_top.sv
